[rtl/assert_macros.svh]
// assertion macros shared by the checker files
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication, held off during reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[rtl/psd_pkg.sv]
// package for the point to segment distance block
// default widths shared by the top level and its checker; no dependencies
package psd_pkg;
  localparam int unsigned DEF_COORD_BITS  = 24;
  localparam int unsigned DEF_T_FRAC_BITS = 16;
endpackage

[rtl/point_segment_distance_top.sv]
// point to segment distance: divider and square root pipelines
// depends on psd_pkg
//
// channel   dir  handshake                 word contents (lowest bit first)
// s_axis    in   s_tvalid_i / s_tready_o   ax ay bx by px py line_width point_radius
// m_axis    out  m_tvalid_o / m_tready_i   dist_res proj_x proj_y collides degenerate
//
// one word accepted per cycle while the output is not stalled; the pipeline
// holds one restoring division step and one square root step per stage.
// rst_ni clears only the stage valid bits; payload registers are not reset.
// a stalled output freezes every stage at once, so nothing is lost or repeated;
// s_tready_o is high whenever the output register is empty or being taken.
module point_segment_distance_top
  import psd_pkg::*;
#(
  parameter int unsigned COORD_BITS  = DEF_COORD_BITS,
  parameter int unsigned T_FRAC_BITS = DEF_T_FRAC_BITS,
  localparam int unsigned InW  = ((8 * COORD_BITS - 2 + 7) / 8) * 8,
  localparam int unsigned OutW = ((3 * COORD_BITS + 3 + 7) / 8) * 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_tvalid_i,
  output logic            s_tready_o,
  // ax, ay, bx, by, px, py, line_width, point_radius, zero fill
  input  logic [InW-1:0]  s_tdata_i,
  output logic            m_tvalid_o,
  input  logic            m_tready_i,
  // dist_res, proj_x, proj_y, collides, degenerate, zero fill
  output logic [OutW-1:0] m_tdata_o
);
  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned T  = T_FRAC_BITS;
  localparam int unsigned LW = 2 * CB + 2;  // squared length
  localparam int unsigned DW = 2 * CB + 3;  // signed dot product
  localparam int unsigned PW = CB + T + 3;  // delta times t
  localparam int unsigned SW = 2 * CB + 2;  // squared distance
  localparam int unsigned RW = CB + 1;      // distance

  // fields carried alongside the division
  typedef struct packed {
    logic signed [CB-1:0] ax;
    logic signed [CB-1:0] ay;
    logic signed [CB-1:0] px;
    logic signed [CB-1:0] py;
    logic signed [CB:0]   abx;
    logic signed [CB:0]   aby;
    logic [CB-1:0]        thr;
    logic                 degen;
    logic                 t_zero;
    logic                 t_one;
  } carry_t;

  logic en;
  assign en         = !m_tvalid_o || m_tready_i;
  assign s_tready_o = en;

  // input unpacking
  logic signed [CB-1:0] in_ax, in_ay, in_bx, in_by, in_px, in_py;
  logic [CB-2:0]        in_lw, in_pr;
  assign in_ax = s_tdata_i[CB-1:0];
  assign in_ay = s_tdata_i[2*CB-1:CB];
  assign in_bx = s_tdata_i[3*CB-1:2*CB];
  assign in_by = s_tdata_i[4*CB-1:3*CB];
  assign in_px = s_tdata_i[5*CB-1:4*CB];
  assign in_py = s_tdata_i[6*CB-1:5*CB];
  assign in_lw = s_tdata_i[7*CB-2:6*CB];
  assign in_pr = s_tdata_i[8*CB-3:7*CB-1];

  // stage 1: differences and threshold
  logic                 v1_q;
  carry_t               c1_q;
  logic signed [CB:0]   pax1_q, pay1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c1_q.ax     <= in_ax;
      c1_q.ay     <= in_ay;
      c1_q.px     <= in_px;
      c1_q.py     <= in_py;
      c1_q.abx    <= (CB+1)'(in_bx) - (CB+1)'(in_ax);
      c1_q.aby    <= (CB+1)'(in_by) - (CB+1)'(in_ay);
      c1_q.thr    <= CB'(in_lw) + CB'(in_pr);
      c1_q.degen  <= 1'b0;
      c1_q.t_zero <= 1'b0;
      c1_q.t_one  <= 1'b0;
      pax1_q      <= (CB+1)'(in_px) - (CB+1)'(in_ax);
      pay1_q      <= (CB+1)'(in_py) - (CB+1)'(in_ay);
    end
  end

  // stage 2: the four products
  logic                   v2_q;
  carry_t                 c2_q;
  logic signed [2*CB+1:0] llx2_q, lly2_q, dpx2_q, dpy2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c2_q   <= c1_q;
      llx2_q <= c1_q.abx * c1_q.abx;
      lly2_q <= c1_q.aby * c1_q.aby;
      dpx2_q <= pax1_q * c1_q.abx;
      dpy2_q <= pay1_q * c1_q.aby;
    end
  end

  // stage 3: length, dot product and clamp decision; head of the divider
  logic [LW-1:0]        l2_s3;
  logic signed [DW-1:0] dot_s3;
  carry_t               c_s3;
  assign l2_s3  = LW'($unsigned(llx2_q)) + LW'($unsigned(lly2_q));
  assign dot_s3 = DW'(dpx2_q) + DW'(dpy2_q);
  always_comb begin
    c_s3        = c2_q;
    c_s3.degen  = (l2_s3 == '0);
    c_s3.t_zero = dot_s3[DW-1] || (dot_s3 == '0);
    c_s3.t_one  = !c_s3.t_zero && (dot_s3 >= $signed({1'b0, l2_s3}));
  end

  // divider pipeline, one quotient bit per stage
  logic          dv_q  [T+1];
  carry_t        dc_q  [T+1];
  logic [LW-1:0] dr_q  [T+1];
  logic [LW-1:0] dl_q  [T+1];
  logic [T-1:0]  dt_q  [T+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= 1'b0;
    end else if (en) begin
      dv_q[0] <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dc_q[0] <= c_s3;
      dr_q[0] <= dot_s3[LW-1:0];
      dl_q[0] <= l2_s3;
      dt_q[0] <= '0;
    end
  end

  for (genvar k = 1; k <= T; k++) begin : g_div
    logic [LW:0] rem2;
    logic        ge;
    assign rem2 = {dr_q[k-1], 1'b0};
    assign ge   = rem2 >= {1'b0, dl_q[k-1]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k] <= 1'b0;
      end else if (en) begin
        dv_q[k] <= dv_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dc_q[k] <= dc_q[k-1];
        dl_q[k] <= dl_q[k-1];
        dr_q[k] <= ge ? LW'(rem2 - {1'b0, dl_q[k-1]}) : LW'(rem2);
        dt_q[k] <= {dt_q[k-1][T-2:0], ge};
      end
    end
  end

  // stage 4: clamp t and scale the segment delta
  logic [T:0]           t_fin;
  logic                 v4_q;
  carry_t               c4_q;
  logic signed [PW-1:0] mx4_q, my4_q;
  always_comb begin
    if (dc_q[T].t_zero) begin
      t_fin = '0;
    end else if (dc_q[T].t_one) begin
      t_fin = (T+1)'(1) << T;
    end else begin
      t_fin = {1'b0, dt_q[T]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en) begin
      v4_q <= dv_q[T];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c4_q  <= dc_q[T];
      mx4_q <= dc_q[T].abx * $signed({1'b0, t_fin});
      my4_q <= dc_q[T].aby * $signed({1'b0, t_fin});
    end
  end

  // stage 5: projection, floor shift then add to A
  logic                 v5_q;
  logic signed [CB-1:0] qx5_q, qy5_q, px5_q, py5_q;
  logic [CB-1:0]        thr5_q;
  logic                 dg5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (en) begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      qx5_q  <= c4_q.ax + mx4_q[T+CB-1:T];
      qy5_q  <= c4_q.ay + my4_q[T+CB-1:T];
      px5_q  <= c4_q.px;
      py5_q  <= c4_q.py;
      thr5_q <= c4_q.thr;
      dg5_q  <= c4_q.degen;
    end
  end

  // stage 6: offset from the projection
  logic                 v6_q;
  logic signed [CB:0]   dx6_q, dy6_q;
  logic signed [CB-1:0] qx6_q, qy6_q;
  logic [CB-1:0]        thr6_q;
  logic                 dg6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
    end else if (en) begin
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx6_q  <= (CB+1)'(px5_q) - (CB+1)'(qx5_q);
      dy6_q  <= (CB+1)'(py5_q) - (CB+1)'(qy5_q);
      qx6_q  <= qx5_q;
      qy6_q  <= qy5_q;
      thr6_q <= thr5_q;
      dg6_q  <= dg5_q;
    end
  end

  // stage 7: squares of the offset and of the threshold
  logic                   v7_q;
  logic signed [2*CB+1:0] sx7_q, sy7_q;
  logic [2*CB-1:0]        th7_q;
  logic signed [CB-1:0]   qx7_q, qy7_q;
  logic                   dg7_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v7_q <= 1'b0;
    end else if (en) begin
      v7_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sx7_q <= dx6_q * dx6_q;
      sy7_q <= dy6_q * dy6_q;
      th7_q <= thr6_q * thr6_q;
      qx7_q <= qx6_q;
      qy7_q <= qy6_q;
      dg7_q <= dg6_q;
    end
  end

  // stage 8: squared distance and collision test; head of the root pipeline
  logic [SW-1:0] sq_s8;
  assign sq_s8 = SW'($unsigned(sx7_q)) + SW'($unsigned(sy7_q));

  logic                 sv_q  [RW+1];
  logic [SW-1:0]        sx_q  [RW+1];
  logic [SW-1:0]        sr_q  [RW+1];
  logic signed [CB-1:0] sqx_q [RW+1];
  logic signed [CB-1:0] sqy_q [RW+1];
  logic                 sco_q [RW+1];
  logic                 sdg_q [RW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q[0] <= 1'b0;
    end else if (en) begin
      sv_q[0] <= v7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sx_q[0]  <= sq_s8;
      sr_q[0]  <= '0;
      sqx_q[0] <= qx7_q;
      sqy_q[0] <= qy7_q;
      sco_q[0] <= sq_s8 <= SW'(th7_q);
      sdg_q[0] <= dg7_q;
    end
  end

  // square root, one result bit per stage
  for (genvar j = 1; j <= RW; j++) begin : g_sqrt
    localparam int unsigned BitPos = SW - 2 * j;
    logic [SW-1:0] bitv;
    logic [SW-1:0] trial;
    logic          ge;
    assign bitv  = SW'(1) << BitPos;
    assign trial = sr_q[j-1] + bitv;
    assign ge    = sx_q[j-1] >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[j] <= 1'b0;
      end else if (en) begin
        sv_q[j] <= sv_q[j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sx_q[j]  <= ge ? sx_q[j-1] - trial : sx_q[j-1];
        sr_q[j]  <= ge ? (sr_q[j-1] >> 1) + bitv : sr_q[j-1] >> 1;
        sqx_q[j] <= sqx_q[j-1];
        sqy_q[j] <= sqy_q[j-1];
        sco_q[j] <= sco_q[j-1];
        sdg_q[j] <= sdg_q[j-1];
      end
    end
  end

  // last root stage is the output register
  assign m_tvalid_o = sv_q[RW];
  assign m_tdata_o  = OutW'({sdg_q[RW], sco_q[RW], sqy_q[RW], sqx_q[RW],
                             sr_q[RW][RW-1:0]});

endmodule

[rtl/psd_checker.sv]
// port-level checker for point_segment_distance_top, with its bind
// depends on psd_pkg and assert_macros.svh
`include "assert_macros.svh"

module psd_checker
  import psd_pkg::*;
#(
  parameter int unsigned COORD_BITS = DEF_COORD_BITS,
  localparam int unsigned OutW    = ((3 * COORD_BITS + 3 + 7) / 8) * 8,
  localparam int unsigned OutUsed = 3 * COORD_BITS + 3
) (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            s_tready_o,
  input logic            m_tvalid_o,
  input logic            m_tready_i,
  input logic [OutW-1:0] m_tdata_o
);
  // input side opens exactly when the output word leaves or is empty
  `ASSERT_IMPLY(a_ready_follows_out, clk_i, rst_ni, 1'b1, s_tready_o == (!m_tvalid_o || m_tready_i))
  // a stalled word stays offered
  `ASSERT_NEXT(a_valid_holds, clk_i, rst_ni, m_tvalid_o && !m_tready_i, m_tvalid_o)
  // and does not change
  `ASSERT_NEXT(a_data_holds, clk_i, rst_ni, m_tvalid_o && !m_tready_i, $stable(m_tdata_o))

  if (OutW > OutUsed) begin : g_pad
    // fill bits above the fields stay zero
    `ASSERT_IMPLY(a_pad_zero, clk_i, rst_ni, m_tvalid_o, m_tdata_o[OutW-1:OutUsed] == '0)
  end
endmodule

bind point_segment_distance_top psd_checker #(.COORD_BITS(COORD_BITS)) u_psd_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tready_o (s_tready_o),
  .m_tvalid_o (m_tvalid_o),
  .m_tready_i (m_tready_i),
  .m_tdata_o  (m_tdata_o)
);

[tb/tb_top.sv]
// self-checking testbench for point_segment_distance_top
// depends on psd_pkg and the block's rtl; predicts each result word in place
`timescale 1ns / 1ps

module tb_top;
  import psd_pkg::*;

  localparam int unsigned CB   = DEF_COORD_BITS;
  localparam int unsigned TF   = DEF_T_FRAC_BITS;
  localparam int unsigned InW  = ((8 * CB - 2 + 7) / 8) * 8;
  localparam int unsigned OutW = ((3 * CB + 3 + 7) / 8) * 8;
  localparam int unsigned NUM_RANDOM = 1000;
  localparam longint unsigned CYCLE_LIMIT = 400000;

  // one query word as sent to the block
  typedef struct packed {
    logic [CB-2:0] point_radius;
    logic [CB-2:0] line_width;
    logic [CB-1:0] py;
    logic [CB-1:0] px;
    logic [CB-1:0] by;
    logic [CB-1:0] bx;
    logic [CB-1:0] ay;
    logic [CB-1:0] ax;
  } query_t;

  // one answer word from the block
  typedef struct packed {
    logic          degenerate;
    logic          collides;
    logic [CB-1:0] proj_y;
    logic [CB-1:0] proj_x;
    logic [CB:0]   dist_res;
  } answer_t;

  logic            clk_i;
  logic            rst_ni;
  logic            s_tvalid_i;
  logic            s_tready_o;
  logic [InW-1:0]  s_tdata_i;
  logic            m_tvalid_o;
  logic            m_tready_i;
  logic [OutW-1:0] m_tdata_o;

  query_t  pending_queries[$];
  answer_t expected_answers[$];
  int      error_count;
  int      queries_sent;
  bit      stimulus_done;
  int      send_gap;
  int      recv_gap;
  int      hold_off_cycles;
  longint unsigned cycle_count;

  point_segment_distance_top DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // floor square root, bit by bit
  function automatic longint unsigned floor_sqrt(input longint unsigned x);
    longint unsigned root;
    longint unsigned one_bit;
    root = 0;
    one_bit = 64'd1 << 62;
    while (one_bit > x) one_bit >>= 2;
    while (one_bit != 0) begin
      if (x >= root + one_bit) begin
        x -= root + one_bit;
        root = (root >> 1) + one_bit;
      end else begin
        root >>= 1;
      end
      one_bit >>= 2;
    end
    return root;
  endfunction

  // nearest point on the segment, distance and flags
  function automatic answer_t nearest_on_segment(input query_t q);
    longint sax, say, sbx, sby, spx, spy, abx, aby, dot_pa, qx, qy, dx, dy;
    longint unsigned len_sq, thr, sq, rem, t_frac;
    answer_t a;
    sax = longint'($signed(q.ax));
    say = longint'($signed(q.ay));
    sbx = longint'($signed(q.bx));
    sby = longint'($signed(q.by));
    spx = longint'($signed(q.px));
    spy = longint'($signed(q.py));
    thr = longint'(q.line_width) + longint'(q.point_radius);
    abx = sbx - sax;
    aby = sby - say;
    len_sq = abx * abx + aby * aby;
    qx = sax;
    qy = say;
    if (len_sq != 0) begin
      dot_pa = (spx - sax) * abx + (spy - say) * aby;
      if (dot_pa <= 0) begin
        t_frac = 0;
      end else if ($unsigned(dot_pa) >= len_sq) begin
        t_frac = 64'd1 << TF;
      end else begin
        // restoring division for the fraction bits of t
        rem = dot_pa;
        t_frac = 0;
        for (int i = 0; i < TF; i++) begin
          rem <<= 1;
          t_frac <<= 1;
          if (rem >= len_sq) begin
            rem -= len_sq;
            t_frac |= 1;
          end
        end
      end
      qx = sax + ((abx * longint'(t_frac)) >>> TF);
      qy = say + ((aby * longint'(t_frac)) >>> TF);
    end
    dx = spx - qx;
    dy = spy - qy;
    sq = dx * dx + dy * dy;
    a.dist_res   = (CB+1)'(floor_sqrt(sq));
    a.proj_x     = qx[CB-1:0];
    a.proj_y     = qy[CB-1:0];
    a.collides   = (sq <= thr * thr);
    a.degenerate = (len_sq == 0);
    return a;
  endfunction

  function automatic logic [CB-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0:       return {1'b0, {(CB-1){1'b1}}};
      1:       return {1'b1, {(CB-1){1'b0}}};
      2:       return CB'($signed($urandom_range(0, 4000)) - 2000);
      default: return CB'($urandom());
    endcase
  endfunction

  function automatic logic [CB-2:0] rand_width();
    case ($urandom_range(0, 3))
      0:       return {(CB-1){1'b1}};
      1:       return (CB-1)'($urandom_range(0, 3000));
      default: return (CB-1)'($urandom());
    endcase
  endfunction

  // directed corner cases then random geometry
  initial begin
    query_t q;
    logic [CB-1:0] cmax, cmin;
    cmax = {1'b0, {(CB-1){1'b1}}};
    cmin = {1'b1, {(CB-1){1'b0}}};
    // all zero: degenerate at origin
    q = '0; pending_queries.push_back(q);
    // degenerate segment away from the point
    q = '0; q.ax = 24'd256; q.ay = 24'd512; q.bx = 24'd256; q.by = 24'd512;
    q.px = 24'd1280; q.py = 24'd1536; q.line_width = 23'd100;
    pending_queries.push_back(q);
    // projection inside the segment
    q = '0; q.bx = 24'd2560; q.px = 24'd1000; q.py = 24'd300;
    q.line_width = 23'd200; q.point_radius = 23'd100;
    pending_queries.push_back(q);
    // projection behind start point
    q.px = CB'(-1000); pending_queries.push_back(q);
    // projection beyond end point
    q.px = 24'd9000; pending_queries.push_back(q);
    // point exactly on start and end
    q.px = 24'd0; q.py = 24'd0; pending_queries.push_back(q);
    q.px = 24'd2560; pending_queries.push_back(q);
    // collision boundary: distance exactly width plus radius
    q.px = 24'd1000; q.py = 24'd300; q.line_width = 23'd150; q.point_radius = 23'd150;
    pending_queries.push_back(q);
    q.line_width = 23'd149; pending_queries.push_back(q);
    // extreme coordinates and widths
    q.ax = cmin; q.ay = cmin; q.bx = cmax; q.by = cmax; q.px = cmax; q.py = cmin;
    q.line_width = '1; q.point_radius = '1; pending_queries.push_back(q);
    q.ax = cmax; q.ay = cmin; q.bx = cmin; q.by = cmax; q.px = cmin; q.py = cmin;
    q.line_width = '0; q.point_radius = '0; pending_queries.push_back(q);
    q.ax = cmax; q.ay = cmax; q.bx = cmax; q.by = cmax; q.px = cmin; q.py = cmin;
    pending_queries.push_back(q);
    q.ax = cmin; q.ay = cmax; q.bx = cmin; q.by = cmin; q.px = cmax; q.py = 24'd0;
    q.line_width = '1; pending_queries.push_back(q);
    // negative slope with rounding toward minus infinity
    q = '0; q.ax = 24'd3; q.bx = CB'(-7); q.by = 24'd5; q.px = CB'(-2); q.py = 24'd2;
    pending_queries.push_back(q);
    q.px = 24'd1; q.py = CB'(-1); pending_queries.push_back(q);
    for (int i = 0; i < NUM_RANDOM; i++) begin
      q.ax = rand_coord(); q.ay = rand_coord();
      case ($urandom_range(0, 9))
        0: begin q.bx = q.ax; q.by = q.ay; end
        1: begin
          q.bx = q.ax + CB'($signed($urandom_range(0, 20)) - 10);
          q.by = q.ay + CB'($signed($urandom_range(0, 20)) - 10);
        end
        default: begin q.bx = rand_coord(); q.by = rand_coord(); end
      endcase
      if ($urandom_range(0, 3) == 0) begin
        q.px = q.ax + CB'($signed($urandom_range(0, 4000)) - 2000);
        q.py = q.ay + CB'($signed($urandom_range(0, 4000)) - 2000);
      end else begin
        q.px = rand_coord(); q.py = rand_coord();
      end
      q.line_width = rand_width();
      q.point_radius = rand_width();
      pending_queries.push_back(q);
    end
    stimulus_done = 1'b1;
  end

  // reset, watchdog and end of run
  initial begin
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    cycle_count = 0;
    while (!(stimulus_done && pending_queries.size() == 0 && !s_tvalid_i
             && expected_answers.size() == 0) && cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      // drain window well beyond the pipeline depth for stray words
      repeat (2 * (TF + CB + 9)) @(posedge clk_i);
      if (error_count == 0) begin
        $display("Testbench completed without errors");
      end else begin
        $display("Testbench completed WITH ERRORS");
      end
      $finish;
    end
  end

  // driver: offers queued queries with random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_tvalid_i   <= 1'b0;
      s_tdata_i    <= '0;
      send_gap     <= 0;
      queries_sent <= 0;
    end else begin
      if (s_tvalid_i && s_tready_o) begin
        expected_answers.push_back(nearest_on_segment(query_t'(s_tdata_i[8*CB-3:0])));
        queries_sent <= queries_sent + 1;
      end
      if (!s_tvalid_i || s_tready_o) begin
        if (send_gap > 0) begin
          send_gap   <= send_gap - 1;
          s_tvalid_i <= 1'b0;
        end else if (pending_queries.size() != 0) begin
          s_tvalid_i <= 1'b1;
          s_tdata_i  <= InW'(pending_queries.pop_front());
          // mostly no gap, sometimes short gaps, rarely long ones
          case ($urandom_range(0, 19))
            0:       send_gap <= $urandom_range(20, 80);
            1, 2, 3: send_gap <= $urandom_range(1, 4);
            default: send_gap <= 0;
          endcase
        end else begin
          s_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: random back-pressure plus one long hold-off, checks each word
  always @(posedge clk_i or negedge rst_ni) begin
    answer_t got, want;
    if (!rst_ni) begin
      m_tready_i      <= 1'b0;
      recv_gap        <= 0;
      hold_off_cycles <= 0;
    end else begin
      if (m_tvalid_o && m_tready_i) begin
        got = answer_t'(m_tdata_o[3*CB+2:0]);
        if (expected_answers.size() == 0) begin
          $display("%0t: unexpected word %h", $time, got);
          error_count++;
        end else begin
          want = expected_answers.pop_front();
          if (got.dist_res !== want.dist_res)
            $display("%0t: dist_res expected %0d got %0d", $time, want.dist_res,
                     got.dist_res);
          if (got.proj_x !== want.proj_x)
            $display("%0t: proj_x expected %h got %h", $time, want.proj_x, got.proj_x);
          if (got.proj_y !== want.proj_y)
            $display("%0t: proj_y expected %h got %h", $time, want.proj_y, got.proj_y);
          if (got.collides !== want.collides)
            $display("%0t: collides expected %b got %b", $time, want.collides,
                     got.collides);
          if (got.degenerate !== want.degenerate)
            $display("%0t: degenerate expected %b got %b", $time, want.degenerate,
                     got.degenerate);
          if (got !== want) error_count++;
        end
      end
      // one long stall once traffic is flowing so the pipeline fills up
      if (queries_sent == 100 && hold_off_cycles == 0) begin
        hold_off_cycles <= 200;
        m_tready_i      <= 1'b0;
      end else if (hold_off_cycles > 1) begin
        hold_off_cycles <= hold_off_cycles - 1;
      end else if (hold_off_cycles == 1) begin
        hold_off_cycles <= -1;
        m_tready_i      <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap   <= recv_gap - 1;
        m_tready_i <= 1'b0;
      end else begin
        m_tready_i <= 1'b1;
        case ($urandom_range(0, 19))
          0:       recv_gap <= $urandom_range(20, 60);
          1, 2, 3: recv_gap <= $urandom_range(1, 4);
          default: recv_gap <= 0;
        endcase
      end
    end
  end

endmodule
